>>> sv/psf_pkg.sv
package psf_pkg;

	// request codes on req_type
	localparam logic [2:0] REQ_WRITE    = 3'd0;
	localparam logic [2:0] REQ_READ     = 3'd1;
	localparam logic [2:0] REQ_FADE_IN  = 3'd2;
	localparam logic [2:0] REQ_FADE_OUT = 3'd3;
	localparam logic [2:0] REQ_TICK     = 3'd4;

	// palette select codes
	localparam logic [1:0] PAL_WORK   = 2'd0;
	localparam logic [1:0] PAL_TARGET = 2'd1;
	localparam logic [1:0] PAL_SECOND = 2'd2;

	// configuration register indexes
	localparam logic CFG_START_COLOR = 1'b0;
	localparam logic CFG_LAST_OFFSET = 1'b1;

	localparam logic [7:0] STEP_SIZE    = 8'd32;
	localparam logic [4:0] LAST_TICK    = 5'd21;
	localparam logic [6:0] DEFAULT_LAST = 7'd63;

	// queue depths
	localparam int CQ_DEPTH = 4;
	localparam int OQ_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_WRITE,
		OP_READ,
		OP_FADE_IN,
		OP_FADE_OUT,
		OP_TICK,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_IN   = 2'd1,
		MODE_OUT  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDATA,
		ST_CLEAR,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// decoded word passed from front to back
	typedef struct packed {
		op_t        op;
		logic [1:0] sel;
		logic [7:0] idx;
		rgb_t       rgb;
	} cmd_t;

	typedef struct packed {
		rgb_t  rgb;
		logic  done;
		mode_t mode;
	} res_t;

	// one fade-in step: blue, then green, then red, only while below target
	function automatic rgb_t step_in(input rgb_t d, input rgb_t t);
		rgb_t o;
		o = d;
		if (t.b > d.b) begin
			o.b = d.b + STEP_SIZE;
		end else if (t.g > d.g) begin
			o.g = d.g + STEP_SIZE;
		end else if (t.r > d.r) begin
			o.r = d.r + STEP_SIZE;
		end
		return o;
	endfunction

	// one fade-out step on the first nonzero channel: red, green, blue
	function automatic rgb_t step_out(input rgb_t d);
		rgb_t o;
		o = d;
		if (d.r != 8'd0) begin
			o.r = d.r - STEP_SIZE;
		end else if (d.g != 8'd0) begin
			o.g = d.g - STEP_SIZE;
		end else if (d.b != 8'd0) begin
			o.b = d.b - STEP_SIZE;
		end
		return o;
	endfunction

endpackage

>>> sv/psf_ram.sv
module psf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/psf_front.sv
module psf_front import psf_pkg::*; #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] req_type,
	input  logic [1:0] palette_sel,
	input  logic [7:0] entry_index,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_pop
);

	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam logic [8:0] N_EXT = 9'(PALETTE_ENTRIES);

	cmd_t                cq_mem [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_q;
	logic [CQ_PTR_W-1:0] rd_q;
	logic [CQ_PTR_W:0]   cnt_q;
	cmd_t                cmd_in;
	logic                do_push;

	// entry index modulo the palette size
	function automatic logic [7:0] wrap_idx(input logic [7:0] n);
		logic [8:0] v;
		v = {1'b0, n};
		for (int k = 0; k < 3; k++) begin
			if (v >= N_EXT) begin
				v = v - N_EXT;
			end
		end
		return v[7:0];
	endfunction

	// classify the incoming word
	always_comb begin
		cmd_in.sel = palette_sel;
		cmd_in.idx = wrap_idx(entry_index);
		cmd_in.rgb = '{r: red_in, g: green_in, b: blue_in};
		unique case (req_type)
			REQ_WRITE:    cmd_in.op = OP_WRITE;
			REQ_READ:     cmd_in.op = OP_READ;
			REQ_FADE_IN:  cmd_in.op = OP_FADE_IN;
			REQ_FADE_OUT: cmd_in.op = OP_FADE_OUT;
			REQ_TICK:     cmd_in.op = OP_TICK;
			default:      cmd_in.op = OP_NOP;
		endcase
	end

	assign full      = (cnt_q == (CQ_PTR_W+1)'(CQ_DEPTH));
	assign do_push   = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = cq_mem[rd_q];

	// command queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({do_push, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// command queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			cq_mem[wr_q] <= cmd_in;
		end
	end

endmodule

>>> sv/psf_back.sv
module psf_back import psf_pkg::*; #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	input  logic       cfg_valid,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output logic       res_empty,
	output res_t       res_head,
	input  logic       res_pop
);

	localparam int IDX_W = $clog2(PALETTE_ENTRIES);
	localparam logic [IDX_W:0] N_EXT = (IDX_W+1)'(PALETTE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(PALETTE_ENTRIES - 1);
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

	state_t state_q, state_d;
	op_t        op_q;
	logic [1:0] sel_q;
	mode_t      mode_q;
	logic [4:0] tick_q;
	logic [7:0] start_q;
	logic [6:0] last_q;
	logic [6:0] cnt_q;
	logic [IDX_W-1:0] addr_q;
	logic [IDX_W-1:0] addr_nxt;
	logic [IDX_W-1:0] base_w;
	logic [IDX_W:0]   base_ext;
	logic [IDX_W-1:0] cmd_idx;
	logic             v_s1;
	logic [IDX_W-1:0] addr_s1;
	logic [4:0]       tick_inc;
	logic             tick_wrap;

	// ram ports
	logic [IDX_W-1:0] raddr;
	logic             we_w, we_t, we_s;
	logic [IDX_W-1:0] waddr_w, waddr_s;
	rgb_t             wdata_w, wdata_s;
	rgb_t             rd_w, rd_t, rd_s;

	// result queue
	res_t                oq_mem [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_wr_q;
	logic [OQ_PTR_W-1:0] oq_rd_q;
	logic [OQ_PTR_W:0]   oq_cnt_q;
	logic                oq_full;
	logic                oq_push;
	logic                oq_pop;
	res_t                res;
	logic                start;

	assign cmd_idx   = cmd.idx[IDX_W-1:0];
	assign base_ext  = (IDX_W+1)'(start_q[7:1]);
	assign base_w    = (base_ext >= N_EXT) ? IDX_W'(base_ext - N_EXT) : base_ext[IDX_W-1:0];
	assign addr_nxt  = (addr_q == LAST_ADDR) ? '0 : addr_q + 1'b1;
	assign tick_inc  = tick_q + 5'd1;
	assign tick_wrap = (tick_inc > LAST_TICK);
	assign oq_full   = (oq_cnt_q == (OQ_PTR_W+1)'(OQ_DEPTH));
	assign start     = cmd_valid && !oq_full;

	psf_ram #(.WIDTH($bits(rgb_t)), .DEPTH(PALETTE_ENTRIES)) u_work_ram (
		.clk   (clk),
		.we    (we_w),
		.waddr (waddr_w),
		.wdata (wdata_w),
		.raddr (raddr),
		.rdata (rd_w)
	);

	psf_ram #(.WIDTH($bits(rgb_t)), .DEPTH(PALETTE_ENTRIES)) u_target_ram (
		.clk   (clk),
		.we    (we_t),
		.waddr (cmd_idx),
		.wdata (cmd.rgb),
		.raddr (raddr),
		.rdata (rd_t)
	);

	psf_ram #(.WIDTH($bits(rgb_t)), .DEPTH(PALETTE_ENTRIES)) u_second_ram (
		.clk   (clk),
		.we    (we_s),
		.waddr (waddr_s),
		.wdata (wdata_s),
		.raddr (raddr),
		.rdata (rd_s)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd.op)
						OP_READ:    state_d = ST_RDATA;
						OP_FADE_IN: state_d = ST_CLEAR;
						OP_TICK:    state_d = (mode_q != MODE_NONE) ? ST_SWEEP : ST_IDLE;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_RDATA:  state_d = ST_IDLE;
			ST_CLEAR:  state_d = (cnt_q == last_q) ? ST_FINISH : ST_CLEAR;
			ST_SWEEP:  state_d = (cnt_q == last_q) ? ST_FINISH : ST_SWEEP;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: ram ports, queue pops and result words
	always_comb begin
		cmd_pop  = 1'b0;
		oq_push  = 1'b0;
		res      = '{rgb: '0, done: 1'b0, mode: mode_q};
		raddr    = addr_q;
		we_w     = 1'b0;
		we_t     = 1'b0;
		we_s     = 1'b0;
		waddr_w  = cmd_idx;
		wdata_w  = cmd.rgb;
		waddr_s  = cmd_idx;
		wdata_s  = cmd.rgb;
		unique case (state_q)
			ST_IDLE: begin
				raddr = cmd_idx;
				if (start) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						OP_WRITE: begin
							we_w    = (cmd.sel == PAL_WORK);
							we_t    = (cmd.sel == PAL_TARGET);
							we_s    = (cmd.sel == PAL_SECOND);
							oq_push = 1'b1;
						end
						OP_FADE_OUT: begin
							res.mode = MODE_OUT;
							oq_push  = 1'b1;
						end
						OP_TICK: begin
							res.done = (mode_q == MODE_NONE);
							oq_push  = (mode_q == MODE_NONE);
						end
						OP_NOP: oq_push = 1'b1;
						default: oq_push = 1'b0;
					endcase
				end
			end
			ST_RDATA: begin
				oq_push = 1'b1;
				case (sel_q)
					PAL_WORK:   res.rgb = rd_w;
					PAL_TARGET: res.rgb = rd_t;
					PAL_SECOND: res.rgb = rd_s;
					default:    res.rgb = '0;
				endcase
			end
			ST_CLEAR: begin
				we_w    = 1'b1;
				waddr_w = addr_q;
				wdata_w = '0;
			end
			ST_SWEEP: begin
				raddr = addr_q;
			end
			ST_FINISH: begin
				oq_push = 1'b1;
				if (op_q == OP_FADE_IN) begin
					res.mode = MODE_IN;
				end else begin
					res.done = tick_wrap;
				end
			end
			default: begin
				raddr = addr_q;
			end
		endcase
		// write-back stage of the tick sweep
		if (v_s1) begin
			we_w    = 1'b1;
			waddr_w = addr_s1;
			wdata_w = (mode_q == MODE_IN) ? step_in(rd_w, rd_t) : step_out(rd_w);
			we_s    = (mode_q == MODE_OUT);
			waddr_s = addr_s1;
			wdata_s = step_out(rd_s);
		end
	end

	// sequencer, fade and config state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_NOP;
			sel_q   <= PAL_WORK;
			mode_q  <= MODE_NONE;
			tick_q  <= '0;
			start_q <= '0;
			last_q  <= DEFAULT_LAST;
			cnt_q   <= '0;
			addr_q  <= '0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == ST_SWEEP);
			if (cfg_valid) begin
				if (cfg_index == CFG_START_COLOR) begin
					start_q <= cfg_data;
				end else begin
					last_q <= cfg_data[6:0];
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q   <= cmd.op;
						sel_q  <= cmd.sel;
						cnt_q  <= '0;
						addr_q <= base_w;
						if (cmd.op == OP_FADE_OUT) begin
							start_q <= '0;
							last_q  <= DEFAULT_LAST;
							tick_q  <= '0;
							mode_q  <= MODE_OUT;
						end
					end
				end
				ST_CLEAR, ST_SWEEP: begin
					cnt_q  <= cnt_q + 7'd1;
					addr_q <= addr_nxt;
				end
				ST_FINISH: begin
					if (op_q == OP_FADE_IN) begin
						mode_q <= MODE_IN;
						tick_q <= '0;
					end else begin
						tick_q <= tick_wrap ? 5'd0 : tick_inc;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// sweep pipeline address
	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
	end

	// result queue
	assign oq_pop    = res_pop && !res_empty;
	assign res_empty = (oq_cnt_q == '0);
	assign res_head  = oq_mem[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			case ({oq_push, oq_pop})
				2'b10:   oq_cnt_q <= oq_cnt_q + 1'b1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 1'b1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_mem[oq_wr_q] <= res;
		end
	end

	// a result word is never written into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		oq_push |-> !oq_full)
		else $error("result queue overflow");

	// the tick counter never passes the last tick
	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q <= LAST_TICK)
		else $error("tick counter out of range");

	// a command word is only taken while the sequencer is idle
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (state_q == ST_IDLE))
		else $error("command taken while busy");

	// write-back of the sweep only follows a sweep cycle
	a_wb_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(state_q == ST_SWEEP))
		else $error("stray write-back");

	// a sweep ends in a result word
	a_finish_push: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) && (cnt_q == last_q) |=> oq_push)
		else $error("sweep ended without result");

endmodule

>>> sv/palette_step_fader.sv
// Step fader over three palettes (working, target, secondary) of PALETTE_ENTRIES RGB entries,
// each held in its own RAM. Input words enter a four-word command queue and results leave
// through a two-word result queue, so either side may stall without blocking the other.
// Each word produces exactly one result. Writes, begin-fade-out, unknown requests and ticks
// with no fade mode are answered from the idle state; reads go through a read-data state
// (registered RAM read). Begin-fade-in picks up the word, clears last_offset+1 working
// entries, one per cycle, and then finishes with its result. A tick in a fade mode runs a
// read-modify-write sweep over the range, one entry per cycle on the shared RAM read
// address with a one-stage write-back, walking the working palette and, in fade-out, the
// secondary palette side by side.
// Config writes are always accepted and must only be issued while the block is idle.
module palette_step_fader import psf_pkg::*; #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] req_type,
	input  logic [1:0] palette_sel,
	input  logic [7:0] entry_index,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic       fade_done,
	output logic [1:0] mode_now,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;
	res_t res_head;

	assign cfg_ready = 1'b1;

	psf_front #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req_type    (req_type),
		.palette_sel (palette_sel),
		.entry_index (entry_index),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop)
	);

	psf_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_empty (empty),
		.res_head  (res_head),
		.res_pop   (pop)
	);

	// result word onto the output ports
	assign red_out   = res_head.rgb.r;
	assign green_out = res_head.rgb.g;
	assign blue_out  = res_head.rgb.b;
	assign fade_done = res_head.done;
	assign mode_now  = res_head.mode;

endmodule

>>> sim/fade_checker.sv
`timescale 1ns / 100ps

// watches both queue sides and the register channel, mirrors the palettes
// and the fade state, and compares every popped word with its prediction
module fade_checker import psf_pkg::*; #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [2:0] req_type,
	input  logic [1:0] palette_sel,
	input  logic [7:0] entry_index,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] red_out,
	input  logic [7:0] green_out,
	input  logic [7:0] blue_out,
	input  logic       fade_done,
	input  logic [1:0] mode_now,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output int         mismatches,
	output int         outstanding
);

	typedef struct {
		rgb_t       color;
		logic       done;
		logic [1:0] mode;
	} reply_t;

	rgb_t       work_pal [PALETTE_ENTRIES];
	rgb_t       goal_pal [PALETTE_ENTRIES];
	rgb_t       alt_pal  [PALETTE_ENTRIES];
	mode_t      fade_state;
	logic [4:0] frame_count;
	logic [7:0] first_color;
	logic [6:0] span_last;
	reply_t     owed_replies [$];

	// fade-in: raise blue, else green, else red, whichever is still short
	function automatic rgb_t approach_goal(input rgb_t cur, input rgb_t goal);
		rgb_t nxt;
		nxt = cur;
		if (goal.b > cur.b) begin
			nxt.b = cur.b + STEP_SIZE;
		end else if (goal.g > cur.g) begin
			nxt.g = cur.g + STEP_SIZE;
		end else if (goal.r > cur.r) begin
			nxt.r = cur.r + STEP_SIZE;
		end
		return nxt;
	endfunction

	// fade-out: lower the first lit channel, red first, wrapping in 8 bits
	function automatic rgb_t dim_entry(input rgb_t cur);
		rgb_t nxt;
		nxt = cur;
		if (cur.r != 8'd0) begin
			nxt.r = cur.r - STEP_SIZE;
		end else if (cur.g != 8'd0) begin
			nxt.g = cur.g - STEP_SIZE;
		end else if (cur.b != 8'd0) begin
			nxt.b = cur.b - STEP_SIZE;
		end
		return nxt;
	endfunction

	// frame counter, reports done on the last tick and starts over
	function automatic logic count_frame();
		frame_count = frame_count + 5'd1;
		if (frame_count > LAST_TICK) begin
			frame_count = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// predict the reply to one accepted word and update the mirrored state
	task automatic apply_request(input logic [2:0] req, input logic [1:0] sel,
			input int idx, input rgb_t wr);
		reply_t rep;
		int     base;
		int     slot;
		int     i;
		rep.color = '0;
		rep.done = 1'b0;
		base = first_color >> 1;
		case (req)
		REQ_WRITE: begin
			case (sel)
			PAL_WORK:   work_pal[idx] = wr;
			PAL_TARGET: goal_pal[idx] = wr;
			PAL_SECOND: alt_pal[idx] = wr;
			default: ;
			endcase
		end
		REQ_READ: begin
			case (sel)
			PAL_WORK:   rep.color = work_pal[idx];
			PAL_TARGET: rep.color = goal_pal[idx];
			PAL_SECOND: rep.color = alt_pal[idx];
			default: ;
			endcase
		end
		REQ_FADE_IN: begin
			for (i = 0; i <= span_last; i++) begin
				work_pal[(base + i) % PALETTE_ENTRIES] = '0;
			end
			frame_count = '0;
			fade_state = MODE_IN;
		end
		REQ_FADE_OUT: begin
			first_color = '0;
			span_last = DEFAULT_LAST;
			frame_count = '0;
			fade_state = MODE_OUT;
		end
		REQ_TICK: begin
			if (fade_state == MODE_IN) begin
				for (i = 0; i <= span_last; i++) begin
					slot = (base + i) % PALETTE_ENTRIES;
					work_pal[slot] = approach_goal(work_pal[slot], goal_pal[slot]);
				end
				rep.done = count_frame();
			end else if (fade_state == MODE_OUT) begin
				for (i = 0; i <= span_last; i++) begin
					slot = (base + i) % PALETTE_ENTRIES;
					work_pal[slot] = dim_entry(work_pal[slot]);
					alt_pal[slot] = dim_entry(alt_pal[slot]);
				end
				rep.done = count_frame();
			end else begin
				rep.done = 1'b1;
			end
		end
		default: ;
		endcase
		rep.mode = fade_state;
		owed_replies.push_back(rep);
	endtask

	// channel monitor
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		int     i;
		if (!arst_n) begin
			for (i = 0; i < PALETTE_ENTRIES; i++) begin
				work_pal[i] = '0;
				goal_pal[i] = '0;
				alt_pal[i] = '0;
			end
			fade_state = MODE_NONE;
			frame_count = '0;
			first_color = '0;
			span_last = DEFAULT_LAST;
			owed_replies.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_START_COLOR: first_color = cfg_data;
				CFG_LAST_OFFSET: span_last = cfg_data[6:0];
				default: ;
				endcase
			end
			// accepted input word
			if (push && !full) begin
				apply_request(req_type, palette_sel, entry_index % PALETTE_ENTRIES,
					{red_in, green_in, blue_in});
			end
			// popped result word
			if (pop && !empty) begin
				if (owed_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected word r=%h g=%h b=%h done=%b mode=%0d",
							red_out, green_out, blue_out, fade_done, mode_now);
					end
				end else begin
					want = owed_replies.pop_front();
					if (want.color.r !== red_out || want.color.g !== green_out ||
							want.color.b !== blue_out || want.done !== fade_done ||
							want.mode !== mode_now) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch at %0t: expected r=%h g=%h b=%h done=%b mode=%0d",
								$realtime, want.color.r, want.color.g, want.color.b,
								want.done, want.mode);
							$display("                got r=%h g=%h b=%h done=%b mode=%0d",
								red_out, green_out, blue_out, fade_done, mode_now);
						end
					end
				end
			end
			outstanding <= owed_replies.size();
		end
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import psf_pkg::*;

	localparam int ENTRIES = 256;
	localparam int RANDOM_WORDS = 400;
	localparam int HOLD_CYCLES = 400;

	// codes outside the legal set
	localparam logic [1:0] PAL_NONE = 2'd3;
	localparam logic [2:0] REQ_FIRST_BAD = 3'd5;
	localparam logic [2:0] REQ_LAST_BAD = 3'd7;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [2:0] req_type = REQ_WRITE;
	logic [1:0] palette_sel = PAL_WORK;
	logic [7:0] entry_index = '0;
	logic [7:0] red_in = '0;
	logic [7:0] green_in = '0;
	logic [7:0] blue_in = '0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       fade_done;
	logic [1:0] mode_now;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = CFG_START_COLOR;
	logic [7:0] cfg_data = '0;
	int         mismatches;
	int         outstanding;

	// sender pacing
	int         burst_left = 0;
	bit         steady = 1'b0;
	bit         hold_go = 1'b0;
	int         words_sent = 0;

	always #4 clk = ~clk;

	palette_step_fader #(.PALETTE_ENTRIES(ENTRIES)) dut (.*);

	fade_checker #(.PALETTE_ENTRIES(ENTRIES)) checker_i (.*);

	// channel value biased toward step multiples and the extremes
	function automatic logic [7:0] pick_channel();
		case ($urandom_range(0, 7))
		0: return 8'h00;
		1: return 8'hff;
		2, 3: return 8'($urandom_range(0, 7) * 32);
		default: return 8'($urandom);
		endcase
	endfunction

	// offer one word, idling between bursts, and return at its accepting edge
	task automatic send_word(input logic [2:0] rq, input logic [1:0] sel,
			input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		int gap;
		if (!steady) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					push <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		req_type <= rq;
		palette_sel <= sel;
		entry_index <= idx;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		words_sent++;
	endtask

	// random read or write, now and then to the bad palette select
	task automatic rand_access();
		logic [1:0] sel;
		sel = ($urandom_range(0, 15) == 0) ? PAL_NONE : 2'($urandom_range(0, 2));
		if ($urandom_range(0, 2) == 0) begin
			send_word(REQ_WRITE, sel, 8'($urandom), pick_channel(), pick_channel(),
				pick_channel());
		end else begin
			send_word(REQ_READ, sel, 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom));
		end
	endtask

	// stop offering and wait until every predicted word has been popped
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// one register beat, valid stays up for the caller to drop
	task automatic cfg_beat(input logic idx, input logic [7:0] d);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic program_range(input logic [7:0] first, input logic [7:0] last);
		cfg_beat(CFG_START_COLOR, first);
		cfg_beat(CFG_LAST_OFFSET, last);
		cfg_valid <= 1'b0;
	endtask

	// receiver: changing pop patterns plus one long hold-off
	initial begin
		int  style;
		int  left;
		bit  held;
		style = 0;
		left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !held) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end
			if (left == 0) begin
				style = $urandom_range(0, 3);
				left = $urandom_range(16, 96);
			end
			left--;
			case (style)
			0: pop <= 1'b1;
			1: pop <= 1'($urandom_range(0, 1));
			2: pop <= ($urandom_range(0, 3) == 0);
			default: pop <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// stimulus and verdict
	initial begin
		logic [1:0] pals [3];
		int         p;
		int         i;
		int         phase;
		int         kind;
		int         ticks;
		int         extra;
		int         stop_at;
		logic [7:0] first;
		logic [7:0] last;
		pals[0] = PAL_WORK;
		pals[1] = PAL_TARGET;
		pals[2] = PAL_SECOND;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		program_range(8'd0, 8'd63);
		repeat (2) @(posedge clk);

		// fill every entry of all three palettes so no read hits an unset word
		for (p = 0; p < 3; p++) begin
			for (i = 0; i < ENTRIES; i++) begin
				send_word(REQ_WRITE, pals[p], 8'(i), pick_channel(), pick_channel(),
					pick_channel());
			end
		end

		// directed: extremes, bad select, bad request types, tick with no mode
		send_word(REQ_WRITE, PAL_WORK, 8'd0, 8'hff, 8'hff, 8'hff);
		send_word(REQ_READ, PAL_WORK, 8'd0, 8'h00, 8'h00, 8'h00);
		send_word(REQ_WRITE, PAL_TARGET, 8'd255, 8'h00, 8'h00, 8'h00);
		send_word(REQ_READ, PAL_TARGET, 8'd255, 8'hff, 8'hff, 8'hff);
		send_word(REQ_WRITE, PAL_SECOND, 8'd128, 8'h80, 8'h40, 8'h20);
		send_word(REQ_READ, PAL_SECOND, 8'd128, 8'h00, 8'h00, 8'h00);
		send_word(REQ_WRITE, PAL_NONE, 8'd5, 8'hff, 8'hff, 8'hff);
		send_word(REQ_READ, PAL_NONE, 8'd5, 8'h00, 8'h00, 8'h00);
		send_word(REQ_FIRST_BAD, PAL_NONE, 8'hff, 8'hff, 8'hff, 8'hff);
		send_word(REQ_FIRST_BAD + 3'd1, PAL_WORK, 8'd0, 8'h00, 8'h00, 8'h00);
		send_word(REQ_LAST_BAD, PAL_NONE, 8'hff, 8'hff, 8'hff, 8'hff);
		send_word(REQ_TICK, PAL_WORK, 8'd0, 8'h00, 8'h00, 8'h00);
		// fade-out also resets the range registers
		send_word(REQ_FADE_OUT, PAL_WORK, 8'd0, 8'h00, 8'h00, 8'h00);
		send_word(REQ_TICK, PAL_WORK, 8'd0, 8'h00, 8'h00, 8'h00);
		send_word(REQ_READ, PAL_WORK, 8'd0, 8'h00, 8'h00, 8'h00);
		send_word(REQ_READ, PAL_SECOND, 8'd63, 8'h00, 8'h00, 8'h00);
		settle();
		// widest range starting at the top of the color numbers
		program_range(8'hff, 8'hff);
		send_word(REQ_FADE_IN, PAL_WORK, 8'd0, 8'h00, 8'h00, 8'h00);
		send_word(REQ_READ, PAL_WORK, 8'd254, 8'h00, 8'h00, 8'h00);
		send_word(REQ_TICK, PAL_WORK, 8'd0, 8'h00, 8'h00, 8'h00);
		send_word(REQ_READ, PAL_WORK, 8'd127, 8'h00, 8'h00, 8'h00);
		send_word(REQ_READ, PAL_TARGET, 8'd127, 8'h00, 8'h00, 8'h00);
		send_word(REQ_TICK, PAL_WORK, 8'd0, 8'h00, 8'h00, 8'h00);

		// random phases, mostly whole fades with reads and writes mixed in
		stop_at = words_sent + RANDOM_WORDS;
		phase = 0;
		while (words_sent < stop_at) begin
			settle();
			case ($urandom_range(0, 5))
			0: begin first = 8'h00; last = 8'h00; end
			1: begin first = 8'hff; last = 8'h7f; end
			2: begin first = 8'hff; last = 8'h00; end
			3: begin first = 8'h00; last = 8'hff; end
			default: begin
				first = 8'($urandom);
				last = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
					8'($urandom_range(0, 15) | ($urandom_range(0, 1) << 7));
			end
			endcase
			program_range(first, last);

			// one phase runs flat out against a stalled receiver
			if (phase == 3) begin
				hold_go <= 1'b1;
				steady = 1'b1;
			end

			// the stalled phase always sends a long run of words
			kind = (phase == 3) ? 9 : $urandom_range(0, 9);
			if (kind < 8) begin
				for (i = $urandom_range(0, 3); i > 0; i--) rand_access();
				send_word((kind < 4) ? REQ_FADE_IN : REQ_FADE_OUT,
					2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom));
				ticks = ($urandom_range(0, 1) == 0) ? $urandom_range(22, 30) :
					$urandom_range(1, 21);
				for (i = 0; i < ticks; i++) begin
					send_word(REQ_TICK, 2'($urandom_range(0, 3)), 8'($urandom),
						8'($urandom), 8'($urandom), 8'($urandom));
					for (extra = $urandom_range(0, 2); extra > 0; extra--) rand_access();
				end
			end else begin
				for (i = 0; i < 20; i++) begin
					send_word(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
						8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				end
			end
			steady = 1'b0;
			phase++;
		end

		settle();
		repeat (140) @(posedge clk);
		if (mismatches == 0) begin
			$display("palette_step_fader test passed");
		end else begin
			$display("palette_step_fader test failed");
		end
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("palette_step_fader test failed");
		$finish;
	end

endmodule
